@@ src/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, codes and the grammar tables of the pushdown syntax checker.
// ----------------------------------------------------------------------------
package pds_pkg;

    typedef logic [1:0] mach_t;
    typedef logic [6:0] node_t;
    typedef logic [6:0] code_t;

    localparam mach_t MACH_PRG = 2'd0;
    localparam mach_t MACH_CMD = 2'd1;
    localparam mach_t MACH_EXP = 2'd2;
    localparam mach_t MACH_LOG = 2'd3;

    localparam node_t START_NODE = 7'd1;

    // Lexeme classes that the grammar refers to by meaning.
    localparam code_t TOK_SEMI   = 7'd14;
    localparam code_t TOK_LPAREN = 7'd27;
    localparam code_t TOK_RPAREN = 7'd28;
    localparam code_t TOK_IDENT  = 7'd100;
    localparam code_t TOK_NUMBER = 7'd101;
    localparam code_t TOK_TEXT   = 7'd102;

    typedef enum logic [2:0] {
        STS_CONSUMED   = 3'd0,
        STS_ACCEPTED   = 3'd1,
        STS_INVALID    = 3'd2,
        STS_INCOMPLETE = 3'd3,
        STS_OVERFLOW   = 3'd4,
        STS_IGNORED    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_RUN = 2'd0,
        PH_FIN = 2'd1,
        PH_ERR = 2'd2
    } phase_t;

    // One arc of the grammar: target node and an optional call of a sub-automaton.
    typedef struct packed {
        logic  hit;
        node_t next;
        logic  push;
        mach_t sub;
        node_t ret;
    } arc_t;

    // Return stack entry: machine above node.
    typedef struct packed {
        mach_t mach;
        node_t node;
    } frame_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        frame_t wdata;
    } pds_stack_cmd_t;

    typedef struct packed {
        logic   empty;
        logic   full;
        frame_t top;
    } pds_stack_sts_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] row;
    } pds_result_t;

    function automatic arc_t jump(input node_t next);
        arc_t a;
        a      = '0;
        a.hit  = 1'b1;
        a.next = next;
        return a;
    endfunction

    function automatic arc_t call(input node_t next, input mach_t sub, input node_t ret);
        arc_t a;
        a      = jump(next);
        a.push = 1'b1;
        a.sub  = sub;
        a.ret  = ret;
        return a;
    endfunction

    // Labelled arc of node (m, n) for token c.
    function automatic arc_t find_arc(input mach_t m, input node_t n, input code_t c);
        arc_t a;
        a = '0;
        case ({m, n})
            {MACH_PRG, 7'd2}:  if (c == TOK_SEMI) a = jump(7'd3);
            {MACH_CMD, 7'd5}: begin
                case (c) inside
                    7'd1, 7'd2: a = jump(7'd11);
                    TOK_IDENT:  a = jump(7'd16);
                    7'd3:       a = jump(7'd71);
                    7'd5:       a = call(7'd50, MACH_LOG, 7'd76);
                    7'd8:       a = jump(7'd41);
                    7'd9:       a = jump(7'd45);
                    TOK_TEXT:   a = jump(7'd6);
                    7'd7:       a = jump(7'd81);
                    default:    a = '0;
                endcase
            end
            {MACH_CMD, 7'd11}: if (c == TOK_IDENT) a = jump(7'd12);
            {MACH_CMD, 7'd12}: begin
                if (c == 7'd15) a = jump(7'd11);
                else if (c == 7'd16) a = call(7'd20, MACH_EXP, 7'd13);
            end
            {MACH_CMD, 7'd13}: if (c == 7'd15) a = jump(7'd11);
            {MACH_CMD, 7'd16}: if (c == 7'd16) a = call(7'd20, MACH_EXP, 7'd6);
            {MACH_CMD, 7'd72}: if (c == 7'd4) a = call(7'd50, MACH_LOG, 7'd6);
            {MACH_CMD, 7'd73}: if (c == TOK_SEMI) a = jump(7'd72);
            {MACH_CMD, 7'd76}: if (c == 7'd6) a = call(7'd5, MACH_CMD, 7'd6);
            {MACH_CMD, 7'd41}: if (c == 7'd10) a = jump(7'd42);
            {MACH_CMD, 7'd42}: if (c == TOK_IDENT) a = jump(7'd43);
            {MACH_CMD, 7'd43}: if (c == 7'd10) a = jump(7'd42);
            {MACH_CMD, 7'd45}: if (c == 7'd11) a = jump(7'd46);
            {MACH_CMD, 7'd46}: if (c == TOK_IDENT) a = jump(7'd47);
            {MACH_CMD, 7'd47}: if (c == 7'd11) a = jump(7'd46);
            {MACH_CMD, 7'd81}: if (c == TOK_TEXT) a = jump(7'd6);
            {MACH_EXP, 7'd20}: begin
                case (c) inside
                    7'd23, 7'd24: a = jump(7'd30);
                    default:      a = '0;
                endcase
            end
            {MACH_EXP, 7'd30}: begin
                case (c) inside
                    TOK_NUMBER, TOK_IDENT: a = jump(7'd21);
                    TOK_LPAREN:            a = jump(7'd32);
                    default:               a = '0;
                endcase
            end
            {MACH_EXP, 7'd33}: if (c == TOK_RPAREN) a = jump(7'd21);
            {MACH_EXP, 7'd21}: begin
                case (c) inside
                    7'd23, 7'd24, 7'd25, 7'd26: a = jump(7'd30);
                    default:                    a = '0;
                endcase
            end
            {MACH_LOG, 7'd50}: begin
                case (c) inside
                    7'd33:        a = jump(7'd50);
                    7'd34, 7'd35: a = jump(7'd61);
                    7'd29:        a = call(7'd50, MACH_LOG, 7'd62);
                    default:      a = '0;
                endcase
            end
            {MACH_LOG, 7'd62}: if (c == 7'd30) a = jump(7'd61);
            {MACH_LOG, 7'd63}: begin
                case (c) inside
                    7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22:
                        a = call(7'd20, MACH_EXP, 7'd61);
                    default: a = '0;
                endcase
            end
            {MACH_LOG, 7'd61}: begin
                case (c) inside
                    7'd31, 7'd32: a = jump(7'd50);
                    default:      a = '0;
                endcase
            end
            default: a = '0;
        endcase
        return a;
    endfunction

    // Non-consuming default arc of node (m, n).
    function automatic arc_t default_arc(input mach_t m, input node_t n);
        arc_t a;
        a = '0;
        case ({m, n})
            {MACH_PRG, 7'd1}:  a = call(7'd5, MACH_CMD, 7'd2);
            {MACH_PRG, 7'd3}:  a = jump(START_NODE);
            {MACH_CMD, 7'd13}: a = jump(7'd6);
            {MACH_CMD, 7'd71}: a = call(7'd5, MACH_CMD, 7'd73);
            {MACH_CMD, 7'd72}: a = jump(7'd71);
            {MACH_CMD, 7'd43}: a = jump(7'd6);
            {MACH_CMD, 7'd47}: a = jump(7'd6);
            {MACH_EXP, 7'd20}: a = jump(7'd30);
            {MACH_EXP, 7'd32}: a = call(7'd20, MACH_EXP, 7'd33);
            {MACH_LOG, 7'd50}: a = call(7'd20, MACH_EXP, 7'd63);
            default:           a = '0;
        endcase
        return a;
    endfunction

    function automatic logic is_final(input mach_t m, input node_t n);
        logic f;
        case ({m, n})
            {MACH_PRG, 7'd3},
            {MACH_CMD, 7'd12},
            {MACH_CMD, 7'd6},
            {MACH_EXP, 7'd21},
            {MACH_LOG, 7'd61}: f = 1'b1;
            default:           f = 1'b0;
        endcase
        return f;
    endfunction

endpackage

@@ src/pds_stack.sv @@
// ----------------------------------------------------------------------------
// pds_stack
// Return stack: a synchronous memory with its fill level and a registered read.
// ----------------------------------------------------------------------------
module pds_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pds_pkg::pds_stack_cmd_t cmd,
    output pds_pkg::pds_stack_sts_t sts
);
    import pds_pkg::*;

    localparam int LvlW  = $clog2(STACK_DEPTH + 1);
    localparam int AddrW = $clog2(STACK_DEPTH);

    frame_t          mem [STACK_DEPTH];
    logic [LvlW-1:0] level_reg;
    logic [LvlW-1:0] level_next;
    logic [LvlW-1:0] level_dec;
    frame_t          rd_data_reg;

    assign level_dec = level_reg - LvlW'(1);

    always_comb begin
        level_next = level_reg;
        if (cmd.push) begin
            level_next = level_reg + LvlW'(1);
        end else if (cmd.pop) begin
            level_next = level_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    // The pushed entry lands at the current level; a pop reads the entry below it.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[level_reg[AddrW-1:0]] <= cmd.wdata;
        end
        if (cmd.pop) begin
            rd_data_reg <= mem[level_dec[AddrW-1:0]];
        end
    end

    assign sts.empty = (level_reg == '0);
    assign sts.full  = (level_reg == LvlW'(STACK_DEPTH));
    assign sts.top   = rd_data_reg;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !sts.full) else $error("push into a full return stack");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !sts.empty) else $error("pop from an empty return stack");
    a_pop_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && !cmd.push) |=> level_reg == $past(level_reg) - LvlW'(1))
        else $error("pop did not lower the level");
`endif

endmodule

@@ src/pds_walker.sv @@
// ----------------------------------------------------------------------------
// pds_walker
// Walks the grammar for one token, one move per cycle, waiting in S_POP after a return.
// ----------------------------------------------------------------------------
module pds_walker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pds_pkg::code_t          in_code,
    input  logic [15:0]             in_row,
    input  logic                    in_last,
    output logic                    res_valid,
    input  logic                    res_ready,
    output pds_pkg::pds_result_t    res,
    output pds_pkg::pds_stack_cmd_t stk_cmd,
    input  pds_pkg::pds_stack_sts_t stk_sts
);
    import pds_pkg::*;

    localparam int WalkLimit = 2 * STACK_DEPTH + 16;
    localparam int CntW      = $clog2(WalkLimit + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_POP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    mach_t           mach_reg, mach_next;
    node_t           node_reg, node_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    code_t           code_reg, code_next;
    logic [15:0]     row_reg, row_next;
    logic            last_reg, last_next;
    pds_result_t     res_reg, res_next;

    arc_t lab_arc;
    arc_t def_arc;
    arc_t sel_arc;

    assign lab_arc = find_arc(mach_reg, node_reg, code_reg);
    assign def_arc = default_arc(mach_reg, node_reg);
    assign sel_arc = lab_arc.hit ? lab_arc : def_arc;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mach_next     = mach_reg;
        node_next     = node_reg;
        cnt_next      = cnt_reg;
        code_next     = code_reg;
        row_next      = row_reg;
        last_next     = last_reg;
        res_next      = res_reg;
        stk_cmd       = '0;
        stk_cmd.wdata = '{mach: mach_reg, node: sel_arc.ret};

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    code_next = in_code;
                    row_next  = in_row;
                    last_next = in_last;
                    cnt_next  = '0;
                    if (phase_reg != PH_RUN) begin
                        res_next   = '{status: STS_IGNORED, row: 16'd0};
                        state_next = S_DONE;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (cnt_reg == CntW'(WalkLimit)) begin
                    res_next   = '{status: STS_INVALID, row: row_reg};
                    phase_next = PH_ERR;
                    state_next = S_DONE;
                end else if (sel_arc.hit) begin
                    if (sel_arc.push && stk_sts.full) begin
                        res_next   = '{status: STS_OVERFLOW, row: row_reg};
                        phase_next = PH_ERR;
                        state_next = S_DONE;
                    end else begin
                        stk_cmd.push = sel_arc.push;
                        node_next    = sel_arc.next;
                        if (sel_arc.push) begin
                            mach_next = sel_arc.sub;
                        end
                        if (!lab_arc.hit) begin
                            cnt_next = cnt_reg + CntW'(1);
                        end else if (last_reg) begin
                            phase_next = PH_FIN;
                            state_next = S_DONE;
                            // A push leaves the stack non-empty, so it can never accept.
                            if (!sel_arc.push && stk_sts.empty
                                    && is_final(mach_reg, sel_arc.next)) begin
                                res_next = '{status: STS_ACCEPTED, row: 16'd0};
                            end else begin
                                res_next = '{status: STS_INCOMPLETE, row: row_reg};
                            end
                        end else begin
                            res_next   = '{status: STS_CONSUMED, row: 16'd0};
                            state_next = S_DONE;
                        end
                    end
                end else if (is_final(mach_reg, node_reg)) begin
                    if (!stk_sts.empty) begin
                        stk_cmd.pop = 1'b1;
                        cnt_next    = cnt_reg + CntW'(1);
                        state_next  = S_POP;
                    end else begin
                        res_next   = '{status: STS_ACCEPTED, row: 16'd0};
                        phase_next = PH_FIN;
                        state_next = S_DONE;
                    end
                end else begin
                    res_next   = '{status: STS_INVALID, row: row_reg};
                    phase_next = PH_ERR;
                    state_next = S_DONE;
                end
            end
            S_POP: begin
                mach_next  = stk_sts.top.mach;
                node_next  = stk_sts.top.node;
                state_next = S_WALK;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_RUN;
            mach_reg  <= MACH_PRG;
            node_reg  <= START_NODE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            mach_reg  <= mach_next;
            node_reg  <= node_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        row_reg  <= row_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_pop_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> $past(stk_cmd.pop))
        else $error("return stack read without a pop");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(WalkLimit)) else $error("walk counter passed its limit");
    a_error_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == STS_INVALID || res.status == STS_OVERFLOW))
        |-> phase_reg == PH_ERR) else $error("error reported without error phase");
    a_push_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_cmd.push |-> (state_reg == S_WALK && !stk_cmd.pop))
        else $error("push outside a walk move");
`endif

endmodule

@@ src/pushdown_syntax_checker.sv @@
// ----------------------------------------------------------------------------
// pushdown_syntax_checker
// Checks a stream of lexeme codes against a fixed four-part grammar.
// ----------------------------------------------------------------------------
// Each input beat carries one token (lexeme code, source row, last flag) and
// produces exactly one result beat with a status and, for errors, the row of
// the offending token. Tokens are processed one at a time: a token is taken in,
// then walks the grammar one arc move at a time (labelled or default), with an
// extra S_POP state for each return from a sub-automaton, because the return
// stack is a synchronous memory with a registered read, and finally hands its
// result to the output register. The walk is bounded at 2 * STACK_DEPTH + 16
// default moves and returns. Once the last token has been seen or an error
// has been reported, every further token answers "ignored" until reset. The
// output register lets the walker take the next token while a result still
// waits for m_tready.
// ----------------------------------------------------------------------------
module pushdown_syntax_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [6:0] token_code, [22:7] token_row, [23] zero
    input  logic        s_tlast,   // last_token
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] status, [18:3] error_row, [23:19] zero
);
    import pds_pkg::*;

    pds_stack_cmd_t stk_cmd;
    pds_stack_sts_t stk_sts;
    pds_result_t    res;
    logic           res_valid;
    logic           res_ready;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [18:0] m_data_reg, m_data_next;

    // The walker sequences the grammar moves and owns all control state.
    pds_walker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tdata[6:0]),
        .in_row    (s_tdata[22:7]),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .stk_cmd   (stk_cmd),
        .stk_sts   (stk_sts)
    );

    // The return stack holds (machine, node) pairs to resume after a call.
    pds_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .sts     (stk_sts)
    );

    // Output register: it takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_data_next = {res.row, res.status};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

endmodule

@@ verif/tb_pushdown_syntax_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pushdown_syntax_checker
// Self-checking bench for the pushdown syntax checker.
// ----------------------------------------------------------------------------
// A token stream is built from the grammar itself, so that almost every token
// walks deep into the sub-automata instead of failing at the first state. The
// stream opens with a short hand-written program, then a statement nested to
// the full height of the return stack, then random statements to 450 tokens.
// The run closes with one ending drawn at random: accepted, incomplete,
// invalid syntax or stack overflow. A handful of random tokens follow, which
// the block must answer as ignored. A scoreboard predicts the status and row
// of every accepted token and compares them with the result beats in order.
// Both sides of the stream insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_pushdown_syntax_checker;

    import pds_pkg::*;

    localparam int STACK_DEPTH = 16;
    // The walk of one token gives up after this many moves.
    localparam int WALK_LIMIT  = 2 * STACK_DEPTH + 16;
    // Cycles to wait after the last result, covering one full walk.
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_TOKENS = 450;

    // Lexeme classes that the package does not name.
    localparam code_t TOK_TYPE_INT  = 7'd1;
    localparam code_t TOK_TYPE_REAL = 7'd2;
    localparam code_t TOK_REPEAT    = 7'd3;
    localparam code_t TOK_UNTIL     = 7'd4;
    localparam code_t TOK_IF        = 7'd5;
    localparam code_t TOK_THEN      = 7'd6;
    localparam code_t TOK_WRITE     = 7'd7;
    localparam code_t TOK_READ      = 7'd8;
    localparam code_t TOK_PRINT     = 7'd9;
    localparam code_t TOK_READ_SEP  = 7'd10;
    localparam code_t TOK_PRINT_SEP = 7'd11;
    localparam code_t TOK_COMMA     = 7'd15;
    localparam code_t TOK_ASSIGN    = 7'd16;
    localparam code_t TOK_REL_FIRST = 7'd17;
    localparam code_t TOK_REL_LAST  = 7'd22;
    localparam code_t TOK_PLUS      = 7'd23;
    localparam code_t TOK_MINUS     = 7'd24;
    localparam code_t TOK_MUL       = 7'd25;
    localparam code_t TOK_DIV       = 7'd26;
    localparam code_t TOK_LBRACKET  = 7'd29;
    localparam code_t TOK_RBRACKET  = 7'd30;
    localparam code_t TOK_AND       = 7'd31;
    localparam code_t TOK_OR        = 7'd32;
    localparam code_t TOK_NOT       = 7'd33;
    localparam code_t TOK_TRUE      = 7'd34;
    localparam code_t TOK_FALSE     = 7'd35;

    // Label of a non-consuming default arc in the grammar table.
    localparam int ANY_TOKEN = -1;

    // Nonterminals of the stream generator. The nesting budget that is left
    // is added to the base, so every symbol below SYM_CMD is a token code.
    localparam int SYM_CMD  = 1000;
    localparam int SYM_EXPR = 1100;
    localparam int SYM_TERM = 1200;
    localparam int SYM_LOG  = 1300;
    localparam int SYM_ATOM = 1400;

    typedef struct packed {
        mach_t mach;
        node_t node;
        int    label;
        node_t next;
        logic  pushes;
        mach_t sub;
        node_t ret;
    } rule_t;

    typedef struct {
        code_t       code;
        logic [15:0] row;
        logic        last;
    } token_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the grammar walk and the queue of the
    // statuses that it predicts.
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        rule_t       rules[$];
        mach_t       mach;
        node_t       node;
        frame_t      stack_mem[STACK_DEPTH];
        int          level;
        phase_t      phase;
        pds_result_t status_q[$];
        int          mismatches;

        function new();
            mach       = MACH_PRG;
            node       = START_NODE;
            level      = 0;
            phase      = PH_RUN;
            mismatches = 0;
            // Program: command, semicolon, and round again.
            add_rule(MACH_PRG, 1, ANY_TOKEN, 5, 1'b1, MACH_CMD, 2);
            add_rule(MACH_PRG, 2, TOK_SEMI, 3);
            add_rule(MACH_PRG, 3, ANY_TOKEN, 1);
            // Command.
            add_rule(MACH_CMD, 5, TOK_TYPE_INT, 11);
            add_rule(MACH_CMD, 5, TOK_TYPE_REAL, 11);
            add_rule(MACH_CMD, 5, TOK_IDENT, 16);
            add_rule(MACH_CMD, 5, TOK_REPEAT, 71);
            add_rule(MACH_CMD, 5, TOK_IF, 50, 1'b1, MACH_LOG, 76);
            add_rule(MACH_CMD, 5, TOK_READ, 41);
            add_rule(MACH_CMD, 5, TOK_PRINT, 45);
            add_rule(MACH_CMD, 5, TOK_TEXT, 6);
            add_rule(MACH_CMD, 5, TOK_WRITE, 81);
            add_rule(MACH_CMD, 11, TOK_IDENT, 12);
            add_rule(MACH_CMD, 12, TOK_COMMA, 11);
            add_rule(MACH_CMD, 12, TOK_ASSIGN, 20, 1'b1, MACH_EXP, 13);
            add_rule(MACH_CMD, 13, TOK_COMMA, 11);
            add_rule(MACH_CMD, 13, ANY_TOKEN, 6);
            add_rule(MACH_CMD, 16, TOK_ASSIGN, 20, 1'b1, MACH_EXP, 6);
            add_rule(MACH_CMD, 71, ANY_TOKEN, 5, 1'b1, MACH_CMD, 73);
            add_rule(MACH_CMD, 72, TOK_UNTIL, 50, 1'b1, MACH_LOG, 6);
            add_rule(MACH_CMD, 72, ANY_TOKEN, 71);
            add_rule(MACH_CMD, 73, TOK_SEMI, 72);
            add_rule(MACH_CMD, 76, TOK_THEN, 5, 1'b1, MACH_CMD, 6);
            add_rule(MACH_CMD, 41, TOK_READ_SEP, 42);
            add_rule(MACH_CMD, 42, TOK_IDENT, 43);
            add_rule(MACH_CMD, 43, TOK_READ_SEP, 42);
            add_rule(MACH_CMD, 43, ANY_TOKEN, 6);
            add_rule(MACH_CMD, 45, TOK_PRINT_SEP, 46);
            add_rule(MACH_CMD, 46, TOK_IDENT, 47);
            add_rule(MACH_CMD, 47, TOK_PRINT_SEP, 46);
            add_rule(MACH_CMD, 47, ANY_TOKEN, 6);
            add_rule(MACH_CMD, 81, TOK_TEXT, 6);
            // Arithmetic expression.
            add_rule(MACH_EXP, 20, TOK_PLUS, 30);
            add_rule(MACH_EXP, 20, TOK_MINUS, 30);
            add_rule(MACH_EXP, 20, ANY_TOKEN, 30);
            add_rule(MACH_EXP, 30, TOK_NUMBER, 21);
            add_rule(MACH_EXP, 30, TOK_IDENT, 21);
            add_rule(MACH_EXP, 30, TOK_LPAREN, 32);
            add_rule(MACH_EXP, 32, ANY_TOKEN, 20, 1'b1, MACH_EXP, 33);
            add_rule(MACH_EXP, 33, TOK_RPAREN, 21);
            add_rule(MACH_EXP, 21, TOK_PLUS, 30);
            add_rule(MACH_EXP, 21, TOK_MINUS, 30);
            add_rule(MACH_EXP, 21, TOK_MUL, 30);
            add_rule(MACH_EXP, 21, TOK_DIV, 30);
            // Logical expression.
            add_rule(MACH_LOG, 50, TOK_NOT, 50);
            add_rule(MACH_LOG, 50, TOK_TRUE, 61);
            add_rule(MACH_LOG, 50, TOK_FALSE, 61);
            add_rule(MACH_LOG, 50, TOK_LBRACKET, 50, 1'b1, MACH_LOG, 62);
            add_rule(MACH_LOG, 50, ANY_TOKEN, 20, 1'b1, MACH_EXP, 63);
            add_rule(MACH_LOG, 62, TOK_RBRACKET, 61);
            for (int rel = TOK_REL_FIRST; rel <= TOK_REL_LAST; rel++) begin
                add_rule(MACH_LOG, 63, rel, 20, 1'b1, MACH_EXP, 61);
            end
            add_rule(MACH_LOG, 61, TOK_AND, 50);
            add_rule(MACH_LOG, 61, TOK_OR, 50);
        endfunction

        function void add_rule(mach_t m, int n, int label, int next,
                               logic pushes = 1'b0, mach_t sub = MACH_PRG, int ret = 0);
            rule_t r;
            r.mach   = m;
            r.node   = node_t'(n);
            r.label  = label;
            r.next   = node_t'(next);
            r.pushes = pushes;
            r.sub    = sub;
            r.ret    = node_t'(ret);
            rules.insert(rules.size(), r);
        endfunction

        // Index of the arc of the current node with this label, or -1.
        function int lookup_rule(int label);
            foreach (rules[i]) begin
                if (rules[i].mach == mach && rules[i].node == node && rules[i].label == label)
                    return i;
            end
            return -1;
        endfunction

        // Follows arc k; a call into a full return stack fails.
        function bit take_rule(int k);
            if (rules[k].pushes) begin
                if (level >= STACK_DEPTH)
                    return 1'b0;
                stack_mem[level].mach = mach;
                stack_mem[level].node = rules[k].ret;
                level++;
                mach = rules[k].sub;
            end
            node = rules[k].next;
            return 1'b1;
        endfunction

        function bit node_is_final();
            case ({mach, node})
                {MACH_PRG, 7'd3},
                {MACH_CMD, 7'd12},
                {MACH_CMD, 7'd6},
                {MACH_EXP, 7'd21},
                {MACH_LOG, 7'd61}: return 1'b1;
                default:           return 1'b0;
            endcase
        endfunction

        // Walks the grammar for one accepted token and queues its status.
        function void note_token(code_t code, logic [15:0] row, logic last);
            pds_result_t r;
            int          k;
            int          moves;
            bit          eat;
            bit          settled;
            bit          stuck;
            r.status = STS_IGNORED;
            r.row    = '0;
            if (phase == PH_RUN) begin
                settled = 1'b0;
                stuck   = 1'b0;
                moves   = 0;
                while (!settled && !stuck && moves < WALK_LIMIT) begin
                    moves++;
                    k   = lookup_rule(int'(code));
                    eat = (k >= 0);
                    if (!eat)
                        k = lookup_rule(ANY_TOKEN);
                    if (k >= 0) begin
                        if (!take_rule(k)) begin
                            settled  = 1'b1;
                            r.status = STS_OVERFLOW;
                            r.row    = row;
                            phase    = PH_ERR;
                        end else if (eat) begin
                            settled = 1'b1;
                            if (!last) begin
                                r.status = STS_CONSUMED;
                            end else begin
                                phase = PH_FIN;
                                if (node_is_final() && level == 0) begin
                                    r.status = STS_ACCEPTED;
                                end else begin
                                    r.status = STS_INCOMPLETE;
                                    r.row    = row;
                                end
                            end
                        end
                    end else if (node_is_final()) begin
                        if (level > 0) begin
                            level--;
                            mach = stack_mem[level].mach;
                            node = stack_mem[level].node;
                        end else begin
                            // Nothing left to return to: the token is dropped.
                            settled  = 1'b1;
                            r.status = STS_ACCEPTED;
                            phase    = PH_FIN;
                        end
                    end else begin
                        stuck = 1'b1;
                    end
                end
                // No rule applied, or the walk ran away.
                if (!settled) begin
                    r.status = STS_INVALID;
                    r.row    = row;
                    phase    = PH_ERR;
                end
            end
            status_q.insert(status_q.size(), r);
        endfunction

        // Compares one result beat with the oldest predicted status.
        function void check_result(logic [23:0] beat);
            pds_result_t want;
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat without a token: status %0d row %0d",
                             $time, beat[2:0], beat[18:3]);
            end else begin
                want = status_q.pop_front();
                if (beat[2:0] !== want.status || beat[18:3] !== want.row) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: status exp %0d got %0d, row exp %0d got %0d",
                                 $time, want.status, beat[2:0], want.row, beat[18:3]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [6:0] token_code, [22:7] token_row, [23] zero
    logic        s_tlast;    // last_token
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [2:0] status, [18:3] error_row, [23:19] zero

    always #5 aclk = ~aclk;

    pushdown_syntax_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    parse_scoreboard sb;
    token_beat_t     beat_q[$];
    // Remaining beats of an idle-free stretch on each side.
    int              send_calm = 0;
    int              recv_calm = 0;

    // Idle cycles before the next beat. Now and then a side runs a stretch of
    // beats with no idling at all.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic void add_token(code_t code);
        token_beat_t t;
        t.code = code;
        t.row  = 16'($urandom_range(0, 16'hFFFF));
        t.last = 1'b0;
        beat_q.insert(beat_q.size(), t);
    endfunction

    // Appends one random, well-formed command. The generator expands the
    // leftmost symbol until only tokens are left; the budget bounds nesting,
    // so the return stack stays well below its depth.
    function automatic void gen_command(int budget);
        int work[$];
        int prod[$];
        int sym;
        int b;
        int n;
        int i;
        work.insert(work.size(), SYM_CMD + budget);
        while (work.size() > 0) begin
            sym = work.pop_front();
            if (sym < SYM_CMD) begin
                add_token(code_t'(sym));
            end else begin
                b = sym % 100;
                prod.delete();
                case (sym - b)
                    SYM_CMD: begin
                        case ($urandom_range(0, (b > 0) ? 7 : 5))
                            0: prod.insert(prod.size(), TOK_TEXT);
                            1: begin
                                prod.insert(prod.size(), TOK_WRITE);
                                prod.insert(prod.size(), TOK_TEXT);
                            end
                            2: begin
                                prod.insert(prod.size(), TOK_READ);
                                n = $urandom_range(1, 3);
                                repeat (n) begin
                                    prod.insert(prod.size(), TOK_READ_SEP);
                                    prod.insert(prod.size(), TOK_IDENT);
                                end
                            end
                            3: begin
                                prod.insert(prod.size(), TOK_PRINT);
                                n = $urandom_range(1, 3);
                                repeat (n) begin
                                    prod.insert(prod.size(), TOK_PRINT_SEP);
                                    prod.insert(prod.size(), TOK_IDENT);
                                end
                            end
                            4: begin
                                prod.insert(prod.size(),
                                            $urandom_range(0, 1) ? TOK_TYPE_INT
                                                                 : TOK_TYPE_REAL);
                                n = $urandom_range(1, 3);
                                for (i = 0; i < n; i++) begin
                                    if (i > 0)
                                        prod.insert(prod.size(), TOK_COMMA);
                                    prod.insert(prod.size(), TOK_IDENT);
                                    if ($urandom_range(0, 1)) begin
                                        prod.insert(prod.size(), TOK_ASSIGN);
                                        prod.insert(prod.size(), SYM_EXPR + b);
                                    end
                                end
                            end
                            5: begin
                                prod.insert(prod.size(), TOK_IDENT);
                                prod.insert(prod.size(), TOK_ASSIGN);
                                prod.insert(prod.size(), SYM_EXPR + b);
                            end
                            6: begin
                                prod.insert(prod.size(), TOK_IF);
                                prod.insert(prod.size(), SYM_LOG + b - 1);
                                prod.insert(prod.size(), TOK_THEN);
                                prod.insert(prod.size(), SYM_CMD + b - 1);
                            end
                            default: begin
                                prod.insert(prod.size(), TOK_REPEAT);
                                n = $urandom_range(1, 3);
                                repeat (n) begin
                                    prod.insert(prod.size(), SYM_CMD + b - 1);
                                    prod.insert(prod.size(), TOK_SEMI);
                                end
                                prod.insert(prod.size(), TOK_UNTIL);
                                prod.insert(prod.size(), SYM_LOG + b - 1);
                            end
                        endcase
                    end
                    SYM_EXPR: begin
                        if ($urandom_range(0, 2) == 0)
                            prod.insert(prod.size(),
                                        $urandom_range(0, 1) ? TOK_PLUS : TOK_MINUS);
                        prod.insert(prod.size(), SYM_TERM + b);
                        n = $urandom_range(0, 2);
                        repeat (n) begin
                            prod.insert(prod.size(), $urandom_range(TOK_PLUS, TOK_DIV));
                            prod.insert(prod.size(), SYM_TERM + b);
                        end
                    end
                    SYM_TERM: begin
                        case ($urandom_range(0, (b > 0) ? 2 : 1))
                            0: prod.insert(prod.size(), TOK_NUMBER);
                            1: prod.insert(prod.size(), TOK_IDENT);
                            default: begin
                                prod.insert(prod.size(), TOK_LPAREN);
                                prod.insert(prod.size(), SYM_EXPR + b - 1);
                                prod.insert(prod.size(), TOK_RPAREN);
                            end
                        endcase
                    end
                    SYM_LOG: begin
                        n = $urandom_range(1, 2);
                        for (i = 0; i < n; i++) begin
                            if (i > 0)
                                prod.insert(prod.size(),
                                            $urandom_range(0, 1) ? TOK_AND : TOK_OR);
                            if ($urandom_range(0, 3) == 0)
                                prod.insert(prod.size(), TOK_NOT);
                            prod.insert(prod.size(), SYM_ATOM + b);
                        end
                    end
                    default: begin
                        case ($urandom_range(0, (b > 0) ? 2 : 1))
                            0: prod.insert(prod.size(),
                                           $urandom_range(0, 1) ? TOK_TRUE : TOK_FALSE);
                            1: begin
                                prod.insert(prod.size(), SYM_EXPR + b);
                                prod.insert(prod.size(),
                                            $urandom_range(TOK_REL_FIRST, TOK_REL_LAST));
                                prod.insert(prod.size(), SYM_EXPR + b);
                            end
                            default: begin
                                prod.insert(prod.size(), TOK_LBRACKET);
                                prod.insert(prod.size(), SYM_LOG + b - 1);
                                prod.insert(prod.size(), TOK_RBRACKET);
                            end
                        endcase
                    end
                endcase
                for (i = prod.size() - 1; i >= 0; i--)
                    work.push_front(prod[i]);
            end
        end
    endfunction

    // Presents one token beat and holds it until the block takes it.
    task automatic send_token(input token_beat_t t);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, t.row, t.code};
        s_tlast  = t.last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_token(t.code, t.row, t.last);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on m_tready, every accepted beat is checked.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        code_t bad;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        sb = new();

        // A short program with each simple command kind once: text, write,
        // read, print and a declaration list with an initializer.
        add_token(TOK_TEXT);      add_token(TOK_SEMI);
        add_token(TOK_WRITE);     add_token(TOK_TEXT);      add_token(TOK_SEMI);
        add_token(TOK_READ);      add_token(TOK_READ_SEP);  add_token(TOK_IDENT);
        add_token(TOK_SEMI);
        add_token(TOK_PRINT);     add_token(TOK_PRINT_SEP); add_token(TOK_IDENT);
        add_token(TOK_PRINT_SEP); add_token(TOK_IDENT);     add_token(TOK_SEMI);
        add_token(TOK_TYPE_INT);  add_token(TOK_IDENT);     add_token(TOK_COMMA);
        add_token(TOK_IDENT);     add_token(TOK_ASSIGN);    add_token(TOK_NUMBER);
        add_token(TOK_SEMI);
        beat_q[0].row = 16'h0000;
        beat_q[1].row = 16'hFFFF;

        // An assignment nested in fourteen parentheses fills the return stack
        // to its last entry without overflowing it.
        add_token(TOK_IDENT);
        add_token(TOK_ASSIGN);
        repeat (14) add_token(TOK_LPAREN);
        add_token(TOK_NUMBER);
        repeat (14) add_token(TOK_RPAREN);
        add_token(TOK_SEMI);

        // Random well-formed statements.
        while (beat_q.size() < RANDOM_TOKENS) begin
            gen_command($urandom_range(0, 5));
            add_token(TOK_SEMI);
        end

        // One way to end the program, drawn at random.
        case ($urandom_range(0, 3))
            0: begin
                // The closing semicolon carries the last flag.
                beat_q[$].last = 1'b1;
            end
            1: begin
                // The last flag arrives inside a command: either at a node
                // that is not final, or at a final one with calls still open.
                if ($urandom_range(0, 1))
                    add_token(TOK_TYPE_INT);
                add_token(TOK_IDENT);
                beat_q[$].last = 1'b1;
            end
            2: begin
                // A token that cannot start a command.
                do bad = code_t'($urandom_range(0, 127));
                while (bad inside {TOK_TYPE_INT, TOK_TYPE_REAL, TOK_REPEAT, TOK_IF,
                                   TOK_WRITE, TOK_READ, TOK_PRINT, TOK_IDENT, TOK_TEXT});
                add_token(bad);
            end
            default: begin
                // Parentheses nested past the depth of the return stack.
                add_token(TOK_IDENT);
                add_token(TOK_ASSIGN);
                repeat (STACK_DEPTH + 4) add_token(TOK_LPAREN);
            end
        endcase
        case ($urandom_range(0, 2))
            0: beat_q[$].row = 16'h0000;
            1: beat_q[$].row = 16'hFFFF;
            default: ;
        endcase

        // Once finished or failed, the block must ignore anything further.
        repeat (10) begin
            add_token(code_t'($urandom_range(0, 127)));
            beat_q[$].last = 1'($urandom_range(0, 1));
        end
        beat_q[$ - 1].code = 7'h00;
        beat_q[$].code     = 7'h7F;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (beat_q[i])
            send_token(beat_q[i]);
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Drain, then give a stray extra beat the chance to show up.
        while (sb.status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard limit, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
